[hw/rtl/tbme_pkg.sv]
// Shared types, constants and register map for the trackball motion-to-events block.
`default_nettype none

package tbme_pkg;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned StampW = 16;
  localparam int unsigned AccW   = 16;
  localparam int unsigned PrecW  = 16;
  localparam int unsigned DivW   = 15;
  localparam int unsigned ModeW  = 2;

  // Stream payload widths
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 24;

  // Configuration port
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Register indices (byte address / 4)
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_PRECISION = 3'd1;
  localparam logic [2:0] REG_DIVIDER   = 3'd2;
  localparam logic [2:0] REG_SWAP      = 3'd3;
  localparam logic [2:0] REG_DEBOUNCE  = 3'd4;

  // Operating modes
  localparam logic [ModeW-1:0] MODE_MOUSE  = 2'd0;
  localparam logic [ModeW-1:0] MODE_CURSOR = 2'd1;
  localparam logic [ModeW-1:0] MODE_VOLUME = 2'd2;
  localparam logic [ModeW-1:0] MODE_LIGHT  = 2'd3;

  // Register reset values
  localparam logic [ModeW-1:0]  RST_MODE      = MODE_VOLUME;
  localparam logic [PrecW-1:0]  RST_PRECISION = 16'd256;
  localparam logic [DivW-1:0]   RST_DIVIDER   = 15'd20;
  localparam logic              RST_SWAP      = 1'b0;
  localparam logic [StampW-1:0] RST_DEBOUNCE  = 16'd5;

  // Step event codes
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_POS  = 2'd1;
  localparam logic [1:0] EV_NEG  = 2'd2;

  // Payout limit per poll
  localparam logic signed [AccW-1:0] PAYOUT_MAX = 16'sd127;

  // Switch bit that carries the click
  localparam int unsigned ClickBit = 7;

  // Acceleration unit phases
  typedef enum logic [1:0] {
    ACC_IDLE,
    ACC_SQUARE,
    ACC_SCALE,
    ACC_DONE
  } acc_phase_e;

  // Top-level sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_X_ACC,
    ST_Y_ACC,
    ST_V_ACC,
    ST_H_ACC,
    ST_V_REM,
    ST_H_REM,
    ST_OUT
  } seq_state_e;

endpackage

`default_nettype wire

[hw/rtl/tbme_accel.sv]
// Shared multiplier unit: signed quadratic acceleration of one axis difference.
`default_nettype none

module tbme_accel (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [tbme_pkg::ByteW-1:0]       pos_i,
  input  wire logic [tbme_pkg::ByteW-1:0]       neg_i,
  input  wire logic                             mouse_i,
  input  wire logic [tbme_pkg::PrecW-1:0]       prec_i,
  output logic                                  done_o,
  output logic signed [tbme_pkg::AccW-1:0]      mag_o
);
  import tbme_pkg::*;

  acc_phase_e phase_q, phase_d;

  logic [ByteW-1:0] abs_q;
  logic             sign_q;
  logic             mouse_q;
  logic [34:0]      prod_q;

  logic signed [ByteW:0] diff;
  logic [ByteW-1:0]      abs_d;
  logic [18:0]           scaled;
  logic [18:0]           op_a;
  logic [15:0]           op_b;
  logic [34:0]           prod;
  logic [14:0]           mag15;

  assign diff  = $signed({1'b0, pos_i}) - $signed({1'b0, neg_i});
  assign abs_d = diff[ByteW] ? 8'(-diff) : diff[ByteW-1:0];

  // Scale the square by five in mouse mode: shift and add
  assign scaled = mouse_q ? ({1'b0, prod_q[15:0], 2'b00} + {3'b000, prod_q[15:0]})
                          : {3'b000, prod_q[15:0]};

  always_comb begin
    if (phase_q == ACC_SQUARE) begin
      op_a = {11'd0, abs_q};
      op_b = {8'd0, abs_q};
    end else begin
      op_a = scaled;
      op_b = prec_i;
    end
  end

  assign prod = {16'd0, op_a} * {19'd0, op_b};

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      ACC_IDLE:   if (start_i) phase_d = ACC_SQUARE;
      ACC_SQUARE: phase_d = ACC_SCALE;
      ACC_SCALE:  phase_d = ACC_DONE;
      ACC_DONE:   phase_d = ACC_IDLE;
      default:    phase_d = ACC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ACC_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == ACC_IDLE && start_i) begin
      abs_q   <= abs_d;
      sign_q  <= diff[ByteW];
      mouse_q <= mouse_i;
    end
    if (phase_q == ACC_SQUARE || phase_q == ACC_SCALE) begin
      prod_q <= prod;
    end
  end

  // Cap at 32767 after dropping the eight fraction bits
  assign mag15  = (|prod_q[34:23]) ? 15'h7FFF : prod_q[22:8];
  assign mag_o  = sign_q ? -$signed({1'b0, mag15}) : $signed({1'b0, mag15});
  assign done_o = (phase_q == ACC_DONE);

endmodule

`default_nettype wire

[hw/rtl/tbme_rem.sv]
// Bit-serial truncated remainder of a signed total by the step divider.
`default_nettype none

module tbme_rem (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [tbme_pkg::AccW-1:0]  dividend_i,
  input  wire logic [tbme_pkg::DivW-1:0]         divisor_i,
  output logic                                   done_o,
  output logic signed [tbme_pkg::AccW-1:0]       rem_o
);
  import tbme_pkg::*;

  logic            busy_q;
  logic            done_q;
  logic [3:0]      cnt_q;
  logic [AccW-1:0] num_q;
  logic [DivW-1:0] rem_q;
  logic [DivW-1:0] div_q;
  logic            neg_q;

  logic [AccW-1:0] trial;
  logic            fits;

  assign trial = {rem_q, num_q[AccW-1]};
  assign fits  = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q && start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      neg_q <= dividend_i[AccW-1];
      num_q <= dividend_i[AccW-1] ? 16'(-dividend_i) : dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      // Bring down one bit; subtract where it fits
      num_q <= {num_q[AccW-2:0], 1'b0};
      rem_q <= fits ? DivW'(trial - {1'b0, div_q}) : trial[DivW-1:0];
    end
  end

  // Remainder takes the sign of the dividend
  assign rem_o  = neg_q ? -$signed({1'b0, rem_q}) : $signed({1'b0, rem_q});
  assign done_o = done_q;

endmodule

`default_nettype wire

[hw/rtl/trackball_motion_to_events.sv]
// Top level: trackball poll to mouse report and step events, with sequencer and registers.
`default_nettype none

// Trackball motion to events.
// Input stream (s_axis): one transfer is one sensor poll. tdata carries the four
// motion count bytes, the switch byte and the millisecond stamp; tuser carries
// the read-ok flag. Output stream (m_axis): exactly one result transfer per poll,
// with the mouse report fields (report flag, button, x and y deltas) and the
// step-mode events (vertical, horizontal, click press and release).
// Timing: a poll is accepted when s_axis_tready is high, which is only while the
// sequencer is idle. One shared multiplier runs two passes per axis (square, then
// scale by precision), for x and y and, in cursor, volume and light modes, also for
// vertical and horizontal; those step modes then add a one-bit-per-cycle remainder
// unit per step axis, skipped with a zero divider. The result is then registered
// and the sequencer goes back to idle for the next poll.
// The output register holds one finished result; if the receiver stalls, the next
// poll is still accepted and worked through, then holds in the final state until
// the output register frees up.
// Reset (rst_ni low, asynchronous): all residues, totals, debounce and click state
// clear, the registers take their defaults (volume mode, unity precision, divider
// 20, no swap, 5 ms debounce) and the output stream drops tvalid. The user must write
// configuration through the APB port only while no poll is in flight; it is not enforced.
module trackball_motion_to_events (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Poll stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [7:0] motion_byte_0, [15:8] motion_byte_1, [23:16] motion_byte_2,
  // [31:24] motion_byte_3, [39:32] switch_byte, [55:40] now_ms
  input  wire logic [tbme_pkg::InDataW-1:0]      s_axis_tdata,
  // [0] read_ok
  input  wire logic                              s_axis_tuser,
  // Result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] report_send, [1] button_one, [9:2] delta_x, [17:10] delta_y,
  // [19:18] vertical_event, [21:20] horizontal_event, [22] click_press,
  // [23] click_release
  output logic [tbme_pkg::OutDataW-1:0]          m_axis_tdata,
  // Configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tbme_pkg::AddrW-1:0]        paddr,
  input  wire logic [tbme_pkg::DataW-1:0]        pwdata,
  output logic [tbme_pkg::DataW-1:0]             prdata,
  output logic                                   pready
);
  import tbme_pkg::*;

  // ---------------------------------------------------------------- helpers
  function automatic logic [AccW-1:0] sat_add(input logic [AccW-1:0] a,
                                              input logic [AccW-1:0] b);
    logic [AccW:0] s;
    s = {a[AccW-1], a} + {b[AccW-1], b};
    if (s[AccW] != s[AccW-1]) begin
      return s[AccW] ? 16'h8000 : 16'h7FFF;
    end
    return s[AccW-1:0];
  endfunction

  function automatic logic [ByteW-1:0] pay_val(input logic signed [AccW-1:0] r);
    if (r > PAYOUT_MAX) begin
      return PAYOUT_MAX[ByteW-1:0];
    end else if (r < -PAYOUT_MAX) begin
      return 8'(-PAYOUT_MAX);
    end
    return r[ByteW-1:0];
  endfunction

  function automatic logic [AccW-1:0] pay_rest(input logic signed [AccW-1:0] r);
    if (r > PAYOUT_MAX) begin
      return 16'(r - PAYOUT_MAX);
    end else if (r < -PAYOUT_MAX) begin
      return 16'(r + PAYOUT_MAX);
    end
    return '0;
  endfunction

  // ---------------------------------------------------------------- registers
  logic [ModeW-1:0]  mode_q;
  logic [PrecW-1:0]  prec_q;
  logic [DivW-1:0]   div_q;
  logic              swap_q;
  logic [StampW-1:0] deb_q;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= RST_MODE;
      prec_q <= RST_PRECISION;
      div_q  <= RST_DIVIDER;
      swap_q <= RST_SWAP;
      deb_q  <= RST_DEBOUNCE;
    end else if (cfg_wr) begin
      unique case (paddr[AddrW-1:2])
        REG_MODE:      mode_q <= pwdata[ModeW-1:0];
        REG_PRECISION: prec_q <= pwdata[PrecW-1:0];
        REG_DIVIDER:   div_q  <= pwdata[DivW-1:0];
        REG_SWAP:      swap_q <= pwdata[0];
        REG_DEBOUNCE:  deb_q  <= pwdata[StampW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[AddrW-1:2])
      REG_MODE:      prdata = {30'd0, mode_q};
      REG_PRECISION: prdata = {16'd0, prec_q};
      REG_DIVIDER:   prdata = {17'd0, div_q};
      REG_SWAP:      prdata = {31'd0, swap_q};
      REG_DEBOUNCE:  prdata = {16'd0, deb_q};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- poll latch
  logic              ok_q;
  logic [ByteW-1:0]  b0_q, b1_q, b2_q, b3_q, sw_q;
  logic [StampW-1:0] now_q;

  // ---------------------------------------------------------------- state
  logic [AccW-1:0]   x_res_q, y_res_q, v_tot_q, h_tot_q;
  logic              deb_act_q;
  logic [StampW-1:0] deb_stamp_q;
  logic              click_held_q;
  logic [1:0]        ev_v_q, ev_h_q;

  // ---------------------------------------------------------------- sequencer
  seq_state_e state_q, state_d;
  logic       launched_q, launched_d;
  logic       accept, acc_start, rem_start, load_out;
  logic       acc_done, rem_done;
  logic       out_valid_q;

  logic                    acc_mouse;
  logic [ByteW-1:0]        acc_pos, acc_neg;
  logic signed [AccW-1:0]  acc_mag;
  logic signed [AccW-1:0]  rem_val;
  logic [AccW-1:0]         rem_dividend;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d   = state_q;
    acc_start = 1'b0;
    rem_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_X_ACC;
      end
      ST_X_ACC: begin
        acc_start = !launched_q;
        if (acc_done) state_d = ST_Y_ACC;
      end
      ST_Y_ACC: begin
        acc_start = !launched_q;
        if (acc_done) state_d = (mode_q == MODE_MOUSE) ? ST_OUT : ST_V_ACC;
      end
      ST_V_ACC: begin
        acc_start = !launched_q;
        if (acc_done) state_d = ST_H_ACC;
      end
      ST_H_ACC: begin
        acc_start = !launched_q;
        if (acc_done) state_d = ST_V_REM;
      end
      ST_V_REM: begin
        if (div_q == '0) begin
          state_d = ST_H_REM;
        end else begin
          rem_start = !launched_q;
          if (rem_done) state_d = ST_H_REM;
        end
      end
      ST_H_REM: begin
        if (div_q == '0) begin
          state_d = ST_OUT;
        end else begin
          rem_start = !launched_q;
          if (rem_done) state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    launched_d = launched_q;
    if (acc_done || rem_done) begin
      launched_d = 1'b0;
    end else if (acc_start || rem_start) begin
      launched_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      launched_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
    end
  end

  // ---------------------------------------------------------------- shared units
  always_comb begin
    acc_pos   = b2_q;
    acc_neg   = b3_q;
    acc_mouse = 1'b1;
    priority case (state_q)
      ST_Y_ACC: begin
        acc_pos = b1_q;
        acc_neg = b0_q;
      end
      ST_V_ACC: begin
        acc_pos   = b0_q;
        acc_neg   = b1_q;
        acc_mouse = 1'b0;
      end
      ST_H_ACC: acc_mouse = 1'b0;
      default: ;
    endcase
  end

  tbme_accel u_accel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc_start),
    .pos_i   (acc_pos),
    .neg_i   (acc_neg),
    .mouse_i (acc_mouse),
    .prec_i  (prec_q),
    .done_o  (acc_done),
    .mag_o   (acc_mag)
  );

  assign rem_dividend = (state_q == ST_V_REM) ? v_tot_q : h_tot_q;

  tbme_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dividend),
    .divisor_i  (div_q),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // ---------------------------------------------------------------- datapath
  logic                   acc_en;
  logic                   sw_hit;
  logic [StampW-1:0]      stamp_new;
  logic [StampW-1:0]      elapsed;
  logic signed [AccW-1:0] div_pos, div_neg;
  logic [1:0]             step_ev;
  logic                   pressed;
  logic [ByteW-1:0]       dx, dy;

  // Residues build up only on a good read with switches idle and no debounce
  assign acc_en    = ok_q && (sw_q == '0) && !deb_act_q;
  assign sw_hit    = (sw_q != '0);
  assign stamp_new = sw_hit ? now_q : deb_stamp_q;
  assign elapsed   = now_q - stamp_new;

  assign div_pos = $signed({1'b0, div_q});
  assign div_neg = -div_pos;

  // Step event from the total before its remainder is taken
  always_comb begin
    step_ev = EV_NONE;
    if ($signed(rem_dividend) >= div_pos) begin
      step_ev = EV_POS;
    end else if ($signed(rem_dividend) <= div_neg) begin
      step_ev = EV_NEG;
    end
  end

  assign pressed = sw_q[ClickBit];
  assign dx      = swap_q ? pay_val(y_res_q) : pay_val(x_res_q);
  assign dy      = swap_q ? pay_val(x_res_q) : pay_val(y_res_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      // Failed reads act as all-zero bytes
      ok_q  <= s_axis_tuser;
      b0_q  <= s_axis_tuser ? s_axis_tdata[7:0]   : '0;
      b1_q  <= s_axis_tuser ? s_axis_tdata[15:8]  : '0;
      b2_q  <= s_axis_tuser ? s_axis_tdata[23:16] : '0;
      b3_q  <= s_axis_tuser ? s_axis_tdata[31:24] : '0;
      sw_q  <= s_axis_tuser ? s_axis_tdata[39:32] : '0;
      now_q <= s_axis_tdata[55:40];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_res_q      <= '0;
      y_res_q      <= '0;
      v_tot_q      <= '0;
      h_tot_q      <= '0;
      deb_act_q    <= 1'b0;
      deb_stamp_q  <= '0;
      click_held_q <= 1'b0;
      ev_v_q       <= EV_NONE;
      ev_h_q       <= EV_NONE;
      out_valid_q  <= 1'b0;
      m_axis_tdata <= '0;
    end else begin
      if (acc_done) begin
        unique case (state_q)
          ST_X_ACC: if (acc_en) x_res_q <= sat_add(x_res_q, acc_mag);
          ST_Y_ACC: begin
            if (acc_en) y_res_q <= sat_add(y_res_q, acc_mag);
            // Switch activity restarts the window; expire it once past the limit
            deb_stamp_q <= stamp_new;
            deb_act_q   <= (sw_hit || deb_act_q) && !(elapsed > deb_q);
          end
          ST_V_ACC: v_tot_q <= sat_add(v_tot_q, acc_mag);
          ST_H_ACC: h_tot_q <= sat_add(h_tot_q, acc_mag);
          default: ;
        endcase
      end

      if (state_q == ST_V_REM && div_q == '0) ev_v_q <= EV_NONE;
      if (state_q == ST_H_REM && div_q == '0) ev_h_q <= EV_NONE;
      if (rem_start) begin
        if (state_q == ST_V_REM) ev_v_q <= step_ev;
        else                     ev_h_q <= step_ev;
      end
      if (rem_done) begin
        if (state_q == ST_V_REM) v_tot_q <= rem_val;
        else                     h_tot_q <= rem_val;
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
        if (mode_q == MODE_MOUSE) begin
          x_res_q      <= pay_rest(x_res_q);
          y_res_q      <= pay_rest(y_res_q);
          m_axis_tdata <= {1'b0, 1'b0, EV_NONE, EV_NONE, dy, dx, pressed,
                           (pressed || dx != '0 || dy != '0)};
        end else begin
          click_held_q <= pressed;
          m_axis_tdata <= {(!pressed && click_held_q && mode_q != MODE_LIGHT),
                           (pressed && !click_held_q),
                           (mode_q == MODE_VOLUME) ? EV_NONE : ev_h_q,
                           ev_v_q, 8'd0, 8'd0, 1'b0, 1'b0};
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;

endmodule

`default_nettype wire
